// ===== rtl/cts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul1;
    logic mul2;
    logic mul3;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic has_track;
    logic last;
  } status_t;

  localparam logic [2:0] REG_CRIT_SCORE = 3'd0;
  localparam logic [2:0] REG_CRIT_TTC   = 3'd1;
  localparam logic [2:0] REG_BRAKE_SCORE = 3'd2;
  localparam logic [2:0] REG_BRAKE_TTC  = 3'd3;
  localparam logic [2:0] REG_WARN_SCORE = 3'd4;
  localparam logic [2:0] REG_WARN_TTC   = 3'd5;

  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_MED  = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;
  localparam logic [1:0] LVL_CRIT = 2'd3;

  localparam int DIV_STEPS = 11;

endpackage
`default_nettype wire

// ===== rtl/cts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire cts_pkg::status_t sts,
  output cts_pkg::cmd_t        cmd
);
  import cts_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_done) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = sts.last ? ST_OUT : ST_IDLE;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_MUL3: cmd.mul3 = 1'b1;
      ST_UPD:  cmd.update = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.emit = !out_stall;
      end
      default: cmd = '0;
    endcase
  end

  a_out_only_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_UPD))
    else $error("result raised without an update");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_div_precedes_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL1) |-> $past(state_r == ST_DIV))
    else $error("multiply started without divide");
endmodule
`default_nettype wire

// ===== rtl/cts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cts_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cts_pkg::cmd_t       cmd,
  output cts_pkg::status_t         sts,
  input  wire logic                in_has_track,
  input  wire logic                in_in_path,
  input  wire logic [15:0]         in_distance,
  input  wire logic [15:0]         in_ttc,
  input  wire logic signed [9:0]   in_lateral_offset,
  input  wire logic [8:0]          in_confidence,
  input  wire logic signed [15:0]  in_ego_speed,
  input  wire logic [15:0]         in_track_id,
  input  wire logic [7:0]          in_class_code,
  input  wire logic                in_last,
  input  wire logic                cfg_valid,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  output logic [1:0]               out_threat_level,
  output logic [10:0]              out_peak_score,
  output logic                     out_hazard_found,
  output logic [15:0]              out_hazard_id,
  output logic [7:0]               out_hazard_class,
  output logic [15:0]              out_hazard_ttc,
  output logic [15:0]              out_hazard_distance
);
  import cts_pkg::*;

  logic [10:0] crit_s_r, brake_s_r, warn_s_r;
  logic [15:0] crit_t_r, brake_t_r, warn_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_s_r <= 11'd870; crit_t_r <= 16'd384;
      brake_s_r <= 11'd700; brake_t_r <= 16'd640;
      warn_s_r <= 11'd450; warn_t_r <= 16'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CRIT_SCORE:  crit_s_r <= cfg_data[10:0];
        REG_CRIT_TTC:    crit_t_r <= cfg_data;
        REG_BRAKE_SCORE: brake_s_r <= cfg_data[10:0];
        REG_BRAKE_TTC:   brake_t_r <= cfg_data;
        REG_WARN_SCORE:  warn_s_r <= cfg_data[10:0];
        REG_WARN_TTC:    warn_t_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request.
  logic        has_r, path_r, last_r;
  logic [15:0] dist_r, ttc_r, id_r;
  logic [7:0]  cls_r;
  logic [9:0]  lat_r;
  logic [8:0]  conf_r;
  logic [15:0] spd_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      has_r <= in_has_track; path_r <= in_in_path; last_r <= in_last;
      dist_r <= in_distance; ttc_r <= in_ttc; id_r <= in_track_id;
      cls_r <= in_class_code; lat_r <= in_lateral_offset;
      conf_r <= in_confidence; spd_r <= in_ego_speed;
    end
  end

  // Prep: stopping distance, floor test and the small factors.
  logic [14:0] v;
  logic [29:0] vsq;
  logic [32:0] n_c;
  assign v   = spd_r[15] ? 15'd0 : spd_r[14:0];
  assign vsq = v * v;
  assign n_c = {v, 12'd0} + {vsq, 2'd0} + {3'd0, vsq};

  logic [33:0] den_r;
  logic        floor_r;
  logic [10:0] ttcf_r, cen_r, spdf_r, conff_r, off_r;

  localparam logic [32:0] DEN_MIN = 33'd15728640;
  logic [32:0] den_c;
  assign den_c = (n_c > DEN_MIN) ? n_c : DEN_MIN;

  logic [41:0] lhs_floor;
  logic [37:0] rhs_floor;
  assign lhs_floor = dist_r * 26'd409600;
  assign rhs_floor = n_c * 5'd23;

  logic [10:0] ttcd;
  logic [20:0] ttcq;
  assign ttcd = 11'd1152 - ttc_r[10:0];
  assign ttcq = 21'((36'({ttcd, 10'd0}) * 36'd18725) >> 24);

  logic [9:0] alat;
  logic [8:0] acl;
  logic [11:0] a8;
  assign alat = lat_r[9] ? (~lat_r + 10'd1) : lat_r;
  assign acl  = (alat > 10'd256) ? 9'd256 : alat[8:0];
  assign a8   = {acl, 3'd0};

  logic [17:0] s4;
  logic [15:0] sq;
  assign s4 = {1'b0, spd_r[14:0], 2'd0};
  assign sq = 16'((34'(s4) * 34'd17477) >> 18);

  logic [12:0] dd;
  assign dd = 13'd7680 - dist_r[12:0];

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      den_r <= {1'b0, den_c};
      floor_r <= (42'(lhs_floor) <= 42'(rhs_floor)) ||
                 ((ttc_r <= 16'd512) && (dist_r <= 16'd6400));
      ttcf_r <= (ttc_r >= 16'd1152) ? 11'd0 :
                ((ttcq > 21'd1024) ? 11'd1024 : ttcq[10:0]);
      // The fifth of the scaled offset is taken by a reciprocal multiply.
      cen_r <= 11'd1024 - 11'((25'(a8) * 25'd13108) >> 16);
      spdf_r <= ($signed(spd_r) <= 0) ? 11'd614 :
                (sq < 16'd614) ? 11'd614 : (sq > 16'd1331) ? 11'd1331 : sq[10:0];
      conff_r <= (conf_r >= 9'd256) ? 11'd1024 :
                 (conf_r < 9'd128) ? 11'd512 : {conf_r[8:0], 2'd0};
      off_r <= (dist_r < 16'd7680) ? 11'((28'(dd) * 28'd13982) >> 20) : 11'd0;
    end
  end

  // Proximity: quotient of (6656*Den - 104857600*d) by 5*Den, restoring, 11 bits.
  logic [3:0]  cnt_r;
  logic [46:0] rem_r;
  logic [36:0] dv_r;
  logic [10:0] q_r;
  logic        pos_r;
  logic [47:0] num_c;
  assign num_c = 48'(den_r) * 48'd6656 - 48'(dist_r) * 48'd104857600;

  always_ff @(posedge clk) begin
    if (cmd.prep) cnt_r <= '0;
    if (cmd.div_step) begin
      if (cnt_r == '0) begin
        pos_r <= !num_c[47] && (num_c != '0);
        rem_r <= num_c[46:0];
        dv_r <= 37'(den_r) * 37'd5;
        q_r <= '0;
        cnt_r <= 4'd1;
      end else if (cnt_r <= 4'(DIV_STEPS)) begin
        if ({1'b0, rem_r} >= (48'(dv_r) << (DIV_STEPS - 32'(cnt_r)))) begin
          rem_r <= 47'({1'b0, rem_r} - (48'(dv_r) << (DIV_STEPS - 32'(cnt_r))));
          q_r[DIV_STEPS - 32'(cnt_r)] <= 1'b1;
        end
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  logic [10:0] prox_c;
  assign prox_c = !pos_r ? 11'd0 : (q_r > 11'd1024 ? 11'd1024 : q_r);

  logic [22:0] m1_r;
  logic [33:0] m2_r;
  logic [44:0] m3_r;
  always_ff @(posedge clk) begin
    if (cmd.mul1) m1_r <= (12'(prox_c) + 12'(ttcf_r)) * cen_r;
    if (cmd.mul2) m2_r <= m1_r * spdf_r;
    if (cmd.mul3) m3_r <= m2_r * conff_r;
  end

  logic [13:0] raw_c;
  logic [10:0] score_c;
  assign raw_c = 14'(m3_r >> 31);
  always_comb begin
    if (!path_r) score_c = off_r;
    else begin
      score_c = (raw_c > 14'd1024) ? 11'd1024 : raw_c[10:0];
      if (floor_r && score_c < 11'd901) score_c = 11'd901;
    end
  end

  logic [10:0] bs_r;
  logic        bv_r;
  logic [15:0] bid_r, bttc_r, bdist_r;
  logic [7:0]  bcls_r;
  logic [10:0] bs_c;
  logic        bv_c;
  logic [15:0] bttc_c;
  logic [10:0] bsc_c;

  always_comb begin
    bs_c = bs_r; bv_c = bv_r; bttc_c = bttc_r;
    if (has_r && score_c > bs_r) begin
      bs_c = score_c; bv_c = 1'b1; bttc_c = ttc_r;
    end
  end
  assign bsc_c = bs_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= '0; bv_r <= 1'b0; bid_r <= '0; bcls_r <= '0;
      bttc_r <= '0; bdist_r <= '0;
    end else if (cmd.update) begin
      if (has_r && score_c > bs_r) begin
        bid_r <= id_r; bcls_r <= cls_r; bdist_r <= dist_r;
      end
      bttc_r <= bttc_c;
      if (last_r) begin
        bs_r <= '0; bv_r <= 1'b0;
        if (bv_c && bsc_c > 11'd51) begin
          out_hazard_found <= 1'b1;
          out_peak_score <= bsc_c;
          out_hazard_id <= (has_r && score_c > bs_r) ? id_r : bid_r;
          out_hazard_class <= (has_r && score_c > bs_r) ? cls_r : bcls_r;
          out_hazard_distance <= (has_r && score_c > bs_r) ? dist_r : bdist_r;
          out_hazard_ttc <= bttc_c;
          if (bsc_c >= crit_s_r || bttc_c <= crit_t_r) out_threat_level <= LVL_CRIT;
          else if (bsc_c >= brake_s_r || bttc_c <= brake_t_r) out_threat_level <= LVL_HIGH;
          else if (bsc_c >= warn_s_r || bttc_c <= warn_t_r) out_threat_level <= LVL_MED;
          else out_threat_level <= LVL_LOW;
        end else begin
          out_hazard_found <= 1'b0; out_peak_score <= '0;
          out_hazard_id <= '0; out_hazard_class <= '0;
          out_hazard_distance <= 16'd25600; out_hazard_ttc <= 16'hFFFF;
          out_threat_level <= LVL_LOW;
        end
      end else begin
        bs_r <= bs_c; bv_r <= bv_c;
      end
    end
  end

  // Last step compares at shift 0.
  assign sts = '{div_done: (cnt_r == 4'(DIV_STEPS + 1)), has_track: has_r, last: last_r};

  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (score_c <= 11'd1024))
    else $error("score out of range");
  a_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && last_r) |=> (bs_r == '0 && !bv_r))
    else $error("frame state not cleared");
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && !last_r) |=> (bs_r >= $past(bs_r)))
    else $error("best score fell within a frame");
endmodule
`default_nettype wire

// ===== rtl/collision_threat_scorer_core.sv =====
// A request passes through the prep, divide, three multiply and update states; on a last item
// the result is then raised in the output state. A new request is taken only back in idle, so
// one request is finished before the next is accepted; the proximity divider is the longest step.
// The block holds further requests until a pending result is taken.
// Reset (rst_n low, synchronous) restores threshold defaults and clears frame state.
`timescale 1ns / 1ps
`default_nettype none
module collision_threat_scorer_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_has_track,
  input  wire logic               in_in_path,
  input  wire logic [15:0]        in_distance,
  input  wire logic [15:0]        in_ttc,
  input  wire logic signed [9:0]  in_lateral_offset,
  input  wire logic [8:0]         in_confidence,
  input  wire logic signed [15:0] in_ego_speed,
  input  wire logic [15:0]        in_track_id,
  input  wire logic [7:0]         in_class_code,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_threat_level,
  output logic [10:0]             out_peak_score,
  output logic                    out_hazard_found,
  output logic [15:0]             out_hazard_id,
  output logic [7:0]              out_hazard_class,
  output logic [15:0]             out_hazard_ttc,
  output logic [15:0]             out_hazard_distance,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import cts_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  cts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  cts_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_has_track(in_has_track), .in_in_path(in_in_path),
    .in_distance(in_distance), .in_ttc(in_ttc),
    .in_lateral_offset(in_lateral_offset), .in_confidence(in_confidence),
    .in_ego_speed(in_ego_speed), .in_track_id(in_track_id),
    .in_class_code(in_class_code), .in_last(in_last),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_threat_level(out_threat_level), .out_peak_score(out_peak_score),
    .out_hazard_found(out_hazard_found), .out_hazard_id(out_hazard_id),
    .out_hazard_class(out_hazard_class), .out_hazard_ttc(out_hazard_ttc),
    .out_hazard_distance(out_hazard_distance)
  );
endmodule
`default_nettype wire
